// ===== hw/rtl/led_strip_chase_controller_unit_assert.svh =====
// ---------------------------------------------------------------------------
// led strip chase controller assertion macros
// shared property forms for the checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef LED_STRIP_CHASE_CONTROLLER_UNIT_ASSERT_SVH
`define LED_STRIP_CHASE_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, skipped while in reset
`define LCC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped while in reset
`define LCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lcc_pkg.sv =====
// ---------------------------------------------------------------------------
// lcc_pkg
// types and constants shared by the led strip chase controller modules
// ---------------------------------------------------------------------------
package lcc_pkg;

    localparam int POS_W      = 6;
    localparam int COLOR_W    = 8;
    localparam int PERIOD_W   = 10;
    localparam int SECONDS_W  = 16;
    localparam int MS_W       = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 40;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MS_W-1:0]     MS_PER_S        = MS_W'(1000);
    localparam logic [MS_W-1:0]     ELAPSED_MAX     = {MS_W{1'b1}};
    localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = PERIOD_W'(120);
    localparam logic [SECONDS_W-1:0] DEFAULT_DUR_RST = SECONDS_W'(5);

    typedef enum logic [S_USER_W-1:0] {
        CMD_SET_COLOR   = 2'd0,
        CMD_CHASE_START = 2'd1,
        CMD_STOP        = 2'd2,
        CMD_TICK        = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DURATION = CFG_IDX_W'(1);

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    // one frame to be drawn by the back end
    typedef struct packed {
        rgb_t             color;
        logic             windowed;
        logic [POS_W-1:0] position;
    } frame_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hw/rtl/led_strip_chase_controller_unit.sv =====
// ---------------------------------------------------------------------------
// led_strip_chase_controller_unit
// frame generator for an led strip: steady color, off and timed chase
// ---------------------------------------------------------------------------
// usage:
//   s_ carries commands (tuser: set color, chase start, stop, tick) with the
//   color and chase duration in tdata. every command but tick gives one frame;
//   a tick gives a frame only while a chase runs.
//   m_ carries one pixel per word, index order, tlast on the last pixel.
//   cfg_ writes the tick period (index 0) and default duration (index 1);
//   cfg_ready is always high.
// order: a command is written into the frame queue; the back end walks the
//   queue head into the output register. throughput: one pixel per cycle
//   while m_tready is high and a frame is queued, set by the single pixel
//   walker in the back end. a command is taken whenever the two-entry frame queue has room.
// reset: synchronous on aresetn low; mode off, no chase, registers at their
//   defaults, no frames pending.
// stall: when m_tready is low the pixel holds, the queue fills, and then
//   s_tready drops until the back end drains a frame.
// ---------------------------------------------------------------------------
`include "led_strip_chase_controller_unit_assert.svh"

module led_strip_chase_controller_unit import lcc_pkg::*; #(
    parameter int PIXEL_COUNT  = 22,
    parameter int CHUNK_LENGTH = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_USER_W-1:0]   s_tuser,   // cmd
    input  logic [S_DATA_W-1:0]   s_tdata,   // red, green, blue, chase seconds
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // pixel_index, pixel_red, pixel_green,
                                             // pixel_blue, zero pad
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    queue_status_t q_status;
    logic          q_push, q_pop;
    frame_desc_t   push_desc, head_desc;
    logic          mid_frame_taken;
    logic          at_last_pos;

    lcc_front #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_desc    (push_desc)
    );

    lcc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .head_desc (head_desc),
        .status    (q_status)
    );

    lcc_back #(
        .PIXEL_COUNT  (PIXEL_COUNT),
        .CHUNK_LENGTH (CHUNK_LENGTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_desc   (head_desc),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign mid_frame_taken = m_tvalid && m_tready && !m_tlast;
    assign at_last_pos     = (m_tdata[POS_W-1:0] == POS_W'(PIXEL_COUNT - 1));

    // a frame, once started, comes out without gaps
    `LCC_ASSERT_NEXT(a_frame_no_gap, aclk, aresetn, mid_frame_taken, m_tvalid, "gap inside a frame")
    // tlast marks exactly the last strip position
    `LCC_ASSERT_IMPL(a_last_index, aclk, aresetn, m_tvalid, m_tlast == at_last_pos, "bad tlast")
    // the queue is never pushed while full
    `LCC_ASSERT_IMPL(a_no_overflow, aclk, aresetn, q_status.full, !q_push, "frame queue overflow")

endmodule

// ===== hw/rtl/lcc_front.sv =====
// ---------------------------------------------------------------------------
// lcc_front
// takes commands and config writes, keeps the mode and chase timing state
// and queues one frame descriptor per frame to be drawn
// ---------------------------------------------------------------------------
module lcc_front import lcc_pkg::*; #(
    parameter int PIXEL_COUNT = 22
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_USER_W-1:0]   s_tuser,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  queue_status_t         q_status,
    output logic                  q_push,
    output frame_desc_t           q_desc
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PIXEL_COUNT - 1);

    logic [PERIOD_W-1:0]  tick_period_reg;
    logic [SECONDS_W-1:0] default_dur_reg;
    logic                 steady_mode_reg,  steady_mode_next;
    logic                 running_reg,      running_next;
    rgb_t                 steady_color_reg, steady_color_next;
    rgb_t                 chase_color_reg,  chase_color_next;
    logic [MS_W-1:0]      total_reg,        total_next;
    logic [MS_W-1:0]      elapsed_reg,      elapsed_next;
    logic [POS_W-1:0]     pos_reg,          pos_next;

    cmd_t                 cmd;
    rgb_t                 in_color;
    logic [SECONDS_W-1:0] in_dur;
    logic [SECONDS_W-1:0] dur_sel;
    logic [MS_W:0]        elapsed_sum;
    logic [MS_W-1:0]      elapsed_sat;
    logic [POS_W-1:0]     pos_inc;
    logic                 accept;

    assign s_tready = !q_status.full;
    assign cfg_ready = 1'b1;
    assign accept = s_tvalid && s_tready;

    assign cmd = cmd_t'(s_tuser);
    assign in_color.red   = s_tdata[7:0];
    assign in_color.green = s_tdata[15:8];
    assign in_color.blue  = s_tdata[23:16];
    assign in_dur = s_tdata[39:24];

    assign dur_sel = (in_dur == '0) ? default_dur_reg : in_dur;
    assign elapsed_sum = {1'b0, elapsed_reg} + (MS_W + 1)'(tick_period_reg);
    assign elapsed_sat = elapsed_sum[MS_W] ? ELAPSED_MAX : elapsed_sum[MS_W-1:0];
    assign pos_inc = (pos_reg == LAST_POS) ? '0 : pos_reg + POS_W'(1);

    always_comb begin
        steady_mode_next  = steady_mode_reg;
        running_next      = running_reg;
        steady_color_next = steady_color_reg;
        chase_color_next  = chase_color_reg;
        total_next        = total_reg;
        elapsed_next      = elapsed_reg;
        pos_next          = pos_reg;
        q_push            = 1'b0;
        q_desc            = '0;
        if (accept) begin
            unique case (cmd)
                CMD_SET_COLOR: begin
                    running_next      = 1'b0;
                    steady_mode_next  = 1'b1;
                    steady_color_next = in_color;
                    q_push            = 1'b1;
                    q_desc.color      = in_color;
                end
                CMD_STOP: begin
                    running_next = 1'b0;
                    steady_mode_next = 1'b0;
                    q_push = 1'b1;
                end
                CMD_CHASE_START: begin
                    chase_color_next = in_color;
                    total_next       = MS_W'(dur_sel) * MS_PER_S;
                    elapsed_next     = '0;
                    pos_next         = '0;
                    running_next     = 1'b1;
                    q_push           = 1'b1;
                    q_desc.color     = in_color;
                    q_desc.windowed  = 1'b1;
                end
                CMD_TICK: begin
                    if (running_reg) begin
                        pos_next     = pos_inc;
                        elapsed_next = elapsed_sat;
                        q_push       = 1'b1;
                        if (elapsed_sat >= total_reg) begin
                            // chase over: fall back to the steady color or black
                            running_next = 1'b0;
                            q_desc.color = steady_mode_reg ? steady_color_reg : '0;
                        end else begin
                            q_desc.color    = chase_color_reg;
                            q_desc.windowed = 1'b1;
                            q_desc.position = pos_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg  <= TICK_PERIOD_RST;
            default_dur_reg  <= DEFAULT_DUR_RST;
            steady_mode_reg  <= 1'b0;
            running_reg      <= 1'b0;
            steady_color_reg <= '0;
            chase_color_reg  <= '0;
            total_reg        <= '0;
            elapsed_reg      <= '0;
            pos_reg          <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_TICK_PERIOD) begin
                    tick_period_reg <= cfg_data[PERIOD_W-1:0];
                end else if (cfg_index == REG_DEFAULT_DURATION) begin
                    default_dur_reg <= cfg_data;
                end
            end
            steady_mode_reg  <= steady_mode_next;
            running_reg      <= running_next;
            steady_color_reg <= steady_color_next;
            chase_color_reg  <= chase_color_next;
            total_reg        <= total_next;
            elapsed_reg      <= elapsed_next;
            pos_reg          <= pos_next;
        end
    end

endmodule

// ===== hw/rtl/lcc_queue.sv =====
// ---------------------------------------------------------------------------
// lcc_queue
// short show-ahead queue of frame descriptors between front and back end
// ---------------------------------------------------------------------------
module lcc_queue import lcc_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  frame_desc_t   push_desc,
    input  logic          pop,
    output frame_desc_t   head_desc,
    output queue_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    frame_desc_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign head_desc = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/lcc_back.sv =====
// ---------------------------------------------------------------------------
// lcc_back
// walks the head descriptor pixel by pixel into the output register
// ---------------------------------------------------------------------------
module lcc_back import lcc_pkg::*; #(
    parameter int PIXEL_COUNT  = 22,
    parameter int CHUNK_LENGTH = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  queue_status_t       q_status,
    input  frame_desc_t         q_desc,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    localparam int D_W = POS_W + 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PIXEL_COUNT - 1);

    logic [POS_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic [POS_W-1:0] index_reg;
    rgb_t             color_reg;
    logic             last_reg;

    logic             load;
    logic [D_W-1:0]   win_off;
    logic             lit;
    rgb_t             pix_color;

    assign load  = !q_status.empty && (!valid_reg || m_tready);
    assign q_pop = load && (cnt_reg == LAST_POS);

    // distance from the window start, wrapped around the strip
    always_comb begin
        win_off = {1'b0, cnt_reg} - {1'b0, q_desc.position};
        if (cnt_reg < q_desc.position) begin
            win_off = win_off + D_W'(PIXEL_COUNT);
        end
    end

    assign lit = (win_off < D_W'(CHUNK_LENGTH));
    assign pix_color = (!q_desc.windowed || lit) ? q_desc.color : '0;

    always_comb begin
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            cnt_next   = q_pop ? '0 : cnt_reg + POS_W'(1);
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            index_reg <= cnt_reg;
            color_reg <= pix_color;
            last_reg  <= (cnt_reg == LAST_POS);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {(M_DATA_W - POS_W - 3 * COLOR_W)'(0),
                       color_reg.blue, color_reg.green, color_reg.red, index_reg};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: led strip chase controller testbench
// drives commands and ticks into the frame generator and checks every pixel
// word against a cycle-free predictor of the strip state, over several
// register settings, random idling on both sides and one long output stall
// ----------------------------------------------------------------------------
module tb import lcc_pkg::*; ();

    localparam int PIXELS        = 22;
    localparam int WINDOW        = 6;
    localparam int MS_PER_SECOND = 1000;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [MS_W-1:0] MS_CEILING = {MS_W{1'b1}};
    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        cmd_t                 cmd;
        rgb_t                 color;
        logic [SECONDS_W-1:0] dur;
    } strip_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] idx;
        rgb_t             color;
        logic             last;
    } pixel_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_USER_W-1:0]   s_tuser   = '0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    led_strip_chase_controller_unit #(
        .PIXEL_COUNT  (PIXELS),
        .CHUNK_LENGTH (WINDOW)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted strip state, starts at the reset values
    logic [PERIOD_W-1:0]  tick_ms    = PERIOD_W'(120);
    logic [SECONDS_W-1:0] default_s  = SECONDS_W'(5);
    logic                 steady_on  = 1'b0;
    logic                 chase_on   = 1'b0;
    rgb_t                 steady_rgb = '0;
    rgb_t                 chase_rgb  = '0;
    logic [MS_W-1:0]      total_ms   = '0;
    logic [MS_W-1:0]      elapsed_ms = '0;
    logic [POS_W-1:0]     win_pos    = '0;

    strip_cmd_t stim_q[$];
    pixel_t     pixel_expect[$];
    strip_cmd_t cur_cmd;
    pixel_t     mon_got, mon_want;
    int         errors      = 0;
    int         quiet_count = 0;
    int         hold_left   = 0;
    bit         idle_on     = 1'b0;
    bit         want_hold   = 1'b0;
    bit         hold_done   = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic push_frame(input rgb_t color, input logic windowed);
        pixel_t px;
        int     offset;
        for (int i = 0; i < PIXELS; i++) begin
            offset   = (i + PIXELS - int'(win_pos)) % PIXELS;
            px.idx   = POS_W'(i);
            px.color = (windowed && offset >= WINDOW) ? rgb_t'('0) : color;
            px.last  = (i == PIXELS - 1);
            pixel_expect.push_back(px);
        end
    endtask

    task automatic predict_frames(input strip_cmd_t it);
        logic [SECONDS_W-1:0] secs;
        logic [MS_W:0]        sum;
        case (it.cmd)
            CMD_SET_COLOR: begin
                chase_on   = 1'b0;
                steady_on  = 1'b1;
                steady_rgb = it.color;
                push_frame(steady_rgb, 1'b0);
            end
            CMD_STOP: begin
                chase_on  = 1'b0;
                steady_on = 1'b0;
                push_frame('0, 1'b0);
            end
            CMD_CHASE_START: begin
                secs       = (it.dur == '0) ? default_s : it.dur;
                chase_rgb  = it.color;
                total_ms   = MS_W'(secs) * MS_W'(MS_PER_SECOND);
                elapsed_ms = '0;
                win_pos    = '0;
                chase_on   = 1'b1;
                push_frame(chase_rgb, 1'b1);
            end
            default: begin
                if (chase_on) begin
                    win_pos    = POS_W'((int'(win_pos) + 1) % PIXELS);
                    sum        = {1'b0, elapsed_ms} + (MS_W + 1)'(tick_ms);
                    elapsed_ms = (sum > MS_CEILING) ? MS_CEILING : sum[MS_W-1:0];
                    if (elapsed_ms >= total_ms) begin
                        chase_on = 1'b0;
                        push_frame(steady_on ? steady_rgb : rgb_t'('0), 1'b0);
                    end else begin
                        push_frame(chase_rgb, 1'b1);
                    end
                end
            end
        endcase
    endtask

    // driver: one command word at a time from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_frames(cur_cmd);
            end
            if (!s_tvalid || s_tready) begin
                if (stim_q.size() != 0 && !(idle_on && $urandom_range(99) < 22)) begin
                    cur_cmd  = stim_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_cmd.cmd;
                    s_tdata  <= {cur_cmd.dur, cur_cmd.color.blue, cur_cmd.color.green,
                                 cur_cmd.color.red};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each pixel word, throttle tready, one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                mon_got.idx         = m_tdata[5:0];
                mon_got.color.red   = m_tdata[13:6];
                mon_got.color.green = m_tdata[21:14];
                mon_got.color.blue  = m_tdata[29:22];
                mon_got.last        = m_tlast;
                if (pixel_expect.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pixel: expected none, ", $time,
                             "actual idx=%0d rgb=%h last=%b",
                             mon_got.idx, mon_got.color, mon_got.last);
                end else begin
                    mon_want = pixel_expect.pop_front();
                    if (mon_got !== mon_want) begin
                        errors++;
                        $display("%0t: pixel mismatch: expected idx=%0d rgb=%h last=%b, ",
                                 $time, mon_want.idx, mon_want.color, mon_want.last,
                                 "actual idx=%0d rgb=%h last=%b",
                                 mon_got.idx, mon_got.color, mon_got.last);
                    end
                end
            end
            if (want_hold && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= idle_on ? ($urandom_range(99) >= 22) : 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic push_item(input cmd_t c, input logic [23:0] rgb,
                             input logic [SECONDS_W-1:0] d);
        strip_cmd_t it;
        it.cmd   = c;
        it.color = rgb;
        it.dur   = d;
        stim_q.push_back(it);
    endtask

    // mostly short chases so they run out, now and then the default or a long one
    function automatic logic [SECONDS_W-1:0] pick_dur();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return '0;
        else if (r < 85)
            return SECONDS_W'($urandom_range(1, 3));
        return SECONDS_W'($urandom);
    endfunction

    task automatic gen_random(input int n);
        int   count, k, r;
        cmd_t c;
        count = 0;
        while (count < n) begin
            r = $urandom_range(99);
            if (r < 65) begin
                push_item(CMD_CHASE_START, 24'($urandom), pick_dur());
                k = $urandom_range(1, 45);
                if (k > n - count - 1)
                    k = n - count - 1;
                for (int j = 0; j < k; j++) begin
                    if ($urandom_range(99) < 4) begin
                        c = ($urandom_range(1) == 0) ? CMD_SET_COLOR : CMD_STOP;
                        push_item(c, 24'($urandom), SECONDS_W'($urandom));
                    end else begin
                        push_item(CMD_TICK, 24'($urandom), SECONDS_W'($urandom));
                    end
                end
                count += 1 + k;
            end else if (r < 82) begin
                push_item(CMD_SET_COLOR, 24'($urandom), SECONDS_W'($urandom));
                count++;
            end else if (r < 94) begin
                push_item(CMD_STOP, 24'($urandom), SECONDS_W'($urandom));
                count++;
            end else begin
                push_item(CMD_TICK, 24'($urandom), SECONDS_W'($urandom));
                count++;
            end
        end
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_TICK_PERIOD)
            tick_ms = val[PERIOD_W-1:0];
        else if (idx == REG_DEFAULT_DURATION)
            default_s = val;
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] period,
                            input logic [CFG_DATA_W-1:0] dflt, input bit spare);
        reg_write(REG_TICK_PERIOD, period);
        reg_write(REG_DEFAULT_DURATION, dflt);
        if (spare) begin
            reg_write(REG_SPARE_A, CFG_DATA_W'($urandom));
            reg_write(REG_SPARE_B, CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // all words taken, all pixels out, then room for a trailing idle tick
    // (sampled at the falling edge so the driver has settled)
    task automatic wait_drain();
        while (stim_q.size() != 0 || s_tvalid) @(negedge aclk);
        while (pixel_expect.size() != 0) @(negedge aclk);
        repeat (PIXELS + 8) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;

        // tick with nothing running, color extremes, stop
        push_item(CMD_TICK, 24'($urandom), SECONDS_W'($urandom));
        push_item(CMD_SET_COLOR, 24'hFFFFFF, 16'hFFFF);
        push_item(CMD_SET_COLOR, 24'h000000, 16'h0000);
        push_item(CMD_STOP, 24'hFFFFFF, 16'hFFFF);
        // one second chase over a steady color ends on the ninth tick
        push_item(CMD_SET_COLOR, 24'h123456, 16'h0000);
        push_item(CMD_CHASE_START, 24'hAA00FF, 16'd1);
        for (int i = 0; i < 9; i++)
            push_item(CMD_TICK, 24'($urandom), SECONDS_W'($urandom));
        push_item(CMD_TICK, 24'($urandom), SECONDS_W'($urandom));
        // zero duration picks the default, set color cuts the chase
        push_item(CMD_CHASE_START, 24'h00FF00, 16'd0);
        push_item(CMD_TICK, 24'($urandom), SECONDS_W'($urandom));
        push_item(CMD_SET_COLOR, 24'h0000FF, 16'd7);
        push_item(CMD_TICK, 24'($urandom), SECONDS_W'($urandom));
        push_item(CMD_CHASE_START, 24'hFFFFFF, 16'hFFFF);
        push_item(CMD_TICK, 24'($urandom), SECONDS_W'($urandom));
        push_item(CMD_STOP, 24'h000000, 16'h0000);
        wait_drain();

        set_regs(16'd1000, 16'd1, 1'b0);
        gen_random(40);
        wait_drain();

        set_regs(16'd1, 16'hFFFF, 1'b1);
        gen_random(30);
        wait_drain();

        // zero period and zero default duration
        set_regs(16'd0, 16'd0, 1'b0);
        gen_random(30);
        wait_drain();

        // no idling here; period bits above the register width are dropped
        idle_on = 1'b0;
        set_regs(16'hFFFF, 16'($urandom_range(1, 2)), 1'b1);
        gen_random(40);
        wait_drain();

        idle_on = 1'b1;
        set_regs(16'($urandom_range(100, 600)), 16'($urandom_range(1, 4)), 1'b0);
        gen_random(40);
        want_hold = 1'b1;
        wait_drain();

        if (pixel_expect.size() != 0)
            $display("%0t: %0d pixels never arrived", $time, pixel_expect.size());
        if (errors == 0 && pixel_expect.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
